// ----- rtl/grid_line_of_sight_defines.svh -----
// assertion macros shared by the line-of-sight block
`ifndef GRID_LINE_OF_SIGHT_DEFINES_SVH
`define GRID_LINE_OF_SIGHT_DEFINES_SVH

`ifndef SYNTH

// expression must hold at every clock edge out of reset
`define GLOS_ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define GLOS_ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`else

`define GLOS_ASSERT_ALWAYS(label, expr, msg)
`define GLOS_ASSERT_IMPLIES(label, ante, cons, msg)

`endif

`endif

// ----- rtl/glos_pkg.sv -----
// types, constants and helpers for the line-of-sight block
package glos_pkg;

	localparam int MAP_COLUMNS = 64;
	localparam int MAP_ROWS    = 64;
	localparam int MAP_CELLS   = MAP_COLUMNS * MAP_ROWS;
	localparam int COL_W       = $clog2(MAP_COLUMNS);
	localparam int ROW_W       = $clog2(MAP_ROWS);
	localparam int ADDR_W      = $clog2(MAP_CELLS);

	// item field widths
	localparam int TCOL_W  = 6;
	localparam int TROW_W  = 6;
	localparam int TVAL_W  = 8;
	localparam int COORD_W = 9;

	// input tdata field positions, lowest bit first
	localparam int TD_TILE_COL = 0;
	localparam int TD_TILE_ROW = TD_TILE_COL + TCOL_W;
	localparam int TD_TILE_VAL = TD_TILE_ROW + TROW_W;
	localparam int TD_SRC_COL  = TD_TILE_VAL + TVAL_W;
	localparam int TD_SRC_ROW  = TD_SRC_COL + COORD_W;
	localparam int TD_TGT_COL  = TD_SRC_ROW + COORD_W;
	localparam int TD_TGT_ROW  = TD_TGT_COL + COORD_W;
	localparam int IN_W        = TD_TGT_ROW + COORD_W;
	localparam int OUT_W       = 8;

	// walker arithmetic widths
	localparam int POS_W = COORD_W + 1;
	localparam int DLT_W = COORD_W + 1;
	localparam int ERR_W = DLT_W + 2;
	localparam int E2_W  = ERR_W + 1;

	localparam logic signed [POS_W-1:0] COL_LIM = POS_W'(MAP_COLUMNS);
	localparam logic signed [POS_W-1:0] ROW_LIM = POS_W'(MAP_ROWS);

	localparam logic [TVAL_W-1:0] TILE_WALL = TVAL_W'(1);

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	typedef enum logic [1:0] {
		REASON_CLEAR   = 2'd0,
		REASON_WALL    = 2'd1,
		REASON_OFF_MAP = 2'd2
	} reason_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WALK
	} back_state_t;

	// classified item as it waits between front and back
	typedef struct packed {
		logic                     is_query;
		logic                     wall;
		logic [ADDR_W-1:0]        addr;
		logic signed [POS_W-1:0]  src_x;
		logic signed [POS_W-1:0]  src_y;
		logic signed [POS_W-1:0]  tgt_x;
		logic signed [POS_W-1:0]  tgt_y;
		logic [DLT_W-1:0]         dx;
		logic [DLT_W-1:0]         dy;
		logic                     sx_neg;
		logic                     sy_neg;
	} glos_item_t;

	typedef struct packed {
		logic       valid;
		glos_item_t item;
	} glos_head_t;

	typedef struct packed {
		logic pop;
		logic clearing;
	} glos_back_stat_t;

	function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
		input logic [COL_W-1:0] col);
		return ADDR_W'(ADDR_W'(row) * ADDR_W'(MAP_COLUMNS) + ADDR_W'(col));
	endfunction

endpackage

// ----- rtl/glos_front.sv -----
// front end: takes items, classifies them and queues them for the walker
module glos_front import glos_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,
	input  logic             s_tuser,
	input  glos_back_stat_t  stat,
	output glos_head_t       head
);

	logic [TCOL_W-1:0]         wr_col;
	logic [TROW_W-1:0]         wr_row;
	logic [TVAL_W-1:0]         wr_val;
	logic signed [COORD_W-1:0] src_col, src_row, tgt_col, tgt_row;
	logic signed [POS_W-1:0]   diff_x, diff_y;
	logic                      wr_in_map;
	logic                      keep;
	logic                      push;
	glos_item_t                ent;

	glos_item_t           q_mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]    wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]      cnt_q;

	always_comb begin
		wr_col  = s_tdata[TD_TILE_COL +: TCOL_W];
		wr_row  = s_tdata[TD_TILE_ROW +: TROW_W];
		wr_val  = s_tdata[TD_TILE_VAL +: TVAL_W];
		src_col = s_tdata[TD_SRC_COL +: COORD_W];
		src_row = s_tdata[TD_SRC_ROW +: COORD_W];
		tgt_col = s_tdata[TD_TGT_COL +: COORD_W];
		tgt_row = s_tdata[TD_TGT_ROW +: COORD_W];

		wr_in_map = (int'(wr_col) < MAP_COLUMNS) && (int'(wr_row) < MAP_ROWS);

		ent.is_query = (s_tuser == CMD_QUERY);
		ent.wall     = (wr_val == TILE_WALL);
		ent.addr     = cell_addr(ROW_W'(wr_row), COL_W'(wr_col));
		ent.src_x    = POS_W'(src_col);
		ent.src_y    = POS_W'(src_row);
		ent.tgt_x    = POS_W'(tgt_col);
		ent.tgt_y    = POS_W'(tgt_row);
		diff_x       = ent.tgt_x - ent.src_x;
		diff_y       = ent.tgt_y - ent.src_y;
		ent.dx       = DLT_W'(diff_x < 0 ? -diff_x : diff_x);
		ent.dy       = DLT_W'(diff_y < 0 ? -diff_y : diff_y);
		ent.sx_neg   = !(ent.src_x < ent.tgt_x);
		ent.sy_neg   = !(ent.src_y < ent.tgt_y);

		// writes outside the map are taken and dropped here
		keep = ent.is_query || wr_in_map;
	end

	assign s_tready   = (cnt_q != (QPTR_W+1)'(QUEUE_DEPTH)) && !stat.clearing;
	assign push       = s_tvalid && s_tready && keep;
	assign head.valid = (cnt_q != '0);
	assign head.item  = q_mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (stat.pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, stat.pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ----- rtl/glos_back.sv -----
// back end: wall map, map writes, line walker and result register
module glos_back import glos_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  glos_head_t       head,
	output glos_back_stat_t  stat,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata
);

	back_state_t state_q, state_nxt;

	logic              wall_mem [MAP_CELLS];
	logic              rdata_q;
	logic [ADDR_W-1:0] clr_q;

	logic signed [POS_W-1:0] x_q, y_q, tx_q, ty_q;
	logic [DLT_W-1:0]        dx_q, dy_q;
	logic                    sx_neg_q, sy_neg_q;
	logic signed [ERR_W-1:0] err_q;
	logic                    pend_q;

	logic    out_valid_q;
	reason_t out_reason_q;

	logic                    at_tgt, off_map, hit, decided, out_free;
	reason_t                 reason;
	logic signed [E2_W-1:0]  e2, dx_e, dy_e;
	logic                    step_x, step_y;
	logic signed [ERR_W-1:0] err_nxt;
	logic [ADDR_W-1:0]       walk_addr;

	logic              mem_we, mem_wd, mem_re;
	logic [ADDR_W-1:0] mem_wa, mem_ra;
	logic              pop, load_query, advance, load_out;

	// tile checks, the registered wall read of the previous tile comes first
	always_comb begin
		at_tgt  = (x_q == tx_q) && (y_q == ty_q);
		off_map = (x_q < 0) || (y_q < 0) || (x_q >= COL_LIM) || (y_q >= ROW_LIM);
		hit     = pend_q && rdata_q;
		decided = hit || at_tgt || off_map;
		priority if (hit) begin
			reason = REASON_WALL;
		end else if (at_tgt) begin
			reason = REASON_CLEAR;
		end else begin
			reason = REASON_OFF_MAP;
		end
		out_free  = !out_valid_q || m_tready;
		walk_addr = cell_addr(ROW_W'(y_q), COL_W'(x_q));
	end

	// one bresenham step
	always_comb begin
		e2      = E2_W'(err_q) <<< 1;
		dx_e    = signed'(E2_W'(dx_q));
		dy_e    = signed'(E2_W'(dy_q));
		step_x  = e2 > -dy_e;
		step_y  = e2 < dx_e;
		err_nxt = err_q - (step_x ? ERR_W'(dy_q) : '0) + (step_y ? ERR_W'(dx_q) : '0);
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_q == ADDR_W'(MAP_CELLS - 1)) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (head.valid && head.item.is_query) begin
					state_nxt = ST_WALK;
				end
			end
			ST_WALK: begin
				if (decided && out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_CLEAR;
		endcase
	end

	always_comb begin
		mem_we     = 1'b0;
		mem_wa     = head.item.addr;
		mem_wd     = head.item.wall;
		mem_re     = 1'b0;
		mem_ra     = walk_addr;
		pop        = 1'b0;
		load_query = 1'b0;
		advance    = 1'b0;
		load_out   = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
				mem_wa = clr_q;
				mem_wd = 1'b0;
			end
			ST_IDLE: begin
				if (head.valid) begin
					pop        = 1'b1;
					mem_we     = !head.item.is_query;
					load_query = head.item.is_query;
				end
			end
			ST_WALK: begin
				if (decided) begin
					load_out = out_free;
				end else begin
					mem_re  = 1'b1;
					advance = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			wall_mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rdata_q <= wall_mem[mem_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (load_query) begin
			x_q      <= head.item.src_x;
			y_q      <= head.item.src_y;
			tx_q     <= head.item.tgt_x;
			ty_q     <= head.item.tgt_y;
			dx_q     <= head.item.dx;
			dy_q     <= head.item.dy;
			sx_neg_q <= head.item.sx_neg;
			sy_neg_q <= head.item.sy_neg;
			err_q    <= ERR_W'(head.item.dx) - ERR_W'(head.item.dy);
		end else if (advance) begin
			err_q <= err_nxt;
			if (step_x) begin
				x_q <= sx_neg_q ? x_q - 1'b1 : x_q + 1'b1;
			end
			if (step_y) begin
				y_q <= sy_neg_q ? y_q - 1'b1 : y_q + 1'b1;
			end
		end
		if (load_out) begin
			out_reason_q <= reason;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (load_query) begin
				pend_q <= 1'b0;
			end else if (advance) begin
				pend_q <= 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign stat.pop      = pop;
	assign stat.clearing = (state_q == ST_CLEAR);
	assign m_tvalid      = out_valid_q;
	assign m_tdata       = {(OUT_W-3)'(0), out_reason_q, out_reason_q == REASON_CLEAR};

endmodule

// ----- rtl/grid_line_of_sight.sv -----
// top level of the tile-map line-of-sight checker
//
//  channel   dir  payload
//  s_*       in   tuser: command; tdata: tile_col, tile_row, tile_value,
//                 source_col, source_row, target_col, target_row
//  m_*       out  tdata: visible, block_reason (one item per query)
//
// after reset the wall map is swept to open, one cell a cycle;
// no item is taken during the sweep
// a map write is done by the walker while it is idle; a query loads the walker, which
// then steps once per tile walked (at most max(|dx|,|dy|) steps) and settles the
// last tile, since the walker reads one cell a cycle from the wall map
// a four-item queue lets input items keep coming while a query walks, and the
// walker only waits when a finished result is still held in the output register
`include "grid_line_of_sight_defines.svh"

module grid_line_of_sight import glos_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	// tile_col, tile_row, tile_value, source_col, source_row, target_col, target_row
	input  logic [IN_W-1:0]  s_tdata,
	// command
	input  logic             s_tuser,
	output logic             m_tvalid,
	input  logic             m_tready,
	// visible, block_reason, zero fill
	output logic [OUT_W-1:0] m_tdata
);

	glos_head_t      head;
	glos_back_stat_t bk_stat;

	glos_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.stat     (bk_stat),
		.head     (head)
	);

	glos_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.stat     (bk_stat),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	`GLOS_ASSERT_IMPLIES(a_no_take_in_sweep, s_tvalid && s_tready, !bk_stat.clearing, "item taken during map sweep")
	`GLOS_ASSERT_IMPLIES(a_no_pop_in_sweep, bk_stat.pop, !bk_stat.clearing && head.valid, "queue popped while sweeping or empty")
	`GLOS_ASSERT_IMPLIES(a_visible_matches, m_tvalid, m_tdata[0] == (m_tdata[2:1] == REASON_CLEAR), "visible flag disagrees with reason")

endmodule

// ----- bench/tb.sv -----
// self-checking testbench for the tile-map line-of-sight checker
module tb;
	import glos_pkg::*;

	typedef struct packed {
		logic    visible;
		reason_t reason;
	} sight_result_t;

	// tracks the wall map and the line-of-sight answers still owed by the block
	class sight_board;
		bit            wall_cell [MAP_CELLS];
		sight_result_t expected_sight [$];
		int            errors;
		int            n_writes;
		int            n_queries;
		int            n_visible;
		int            n_wall;
		int            n_off_map;

		function new();
			foreach (wall_cell[i])
				wall_cell[i] = 1'b0;
		endfunction

		function int pending();
			return expected_sight.size();
		endfunction

		// bresenham walk; every tile before the target is checked, bounds first
		function reason_t trace_sight(int x, int y, int tx, int ty);
			int dx;
			int dy;
			int sx;
			int sy;
			int err;
			int e2;
			dx = (tx > x) ? tx - x : x - tx;
			dy = (ty > y) ? ty - y : y - ty;
			sx = (x < tx) ? 1 : -1;
			sy = (y < ty) ? 1 : -1;
			err = dx - dy;
			while (x != tx || y != ty) begin
				if (x < 0 || y < 0 || x >= MAP_COLUMNS || y >= MAP_ROWS)
					return REASON_OFF_MAP;
				if (wall_cell[y * MAP_COLUMNS + x])
					return REASON_WALL;
				e2 = 2 * err;
				if (e2 > -dy) begin
					err -= dy;
					x += sx;
				end
				if (e2 < dx) begin
					err += dx;
					y += sy;
				end
			end
			return REASON_CLEAR;
		endfunction

		function void note_item(logic cmd, logic [IN_W-1:0] data);
			logic signed [COORD_W-1:0] src_col;
			logic signed [COORD_W-1:0] src_row;
			logic signed [COORD_W-1:0] tgt_col;
			logic signed [COORD_W-1:0] tgt_row;
			int                        col;
			int                        row;
			sight_result_t             want;
			if (cmd == CMD_WRITE) begin
				col = data[TD_TILE_COL +: TCOL_W];
				row = data[TD_TILE_ROW +: TROW_W];
				if (col < MAP_COLUMNS && row < MAP_ROWS)
					wall_cell[row * MAP_COLUMNS + col] = (data[TD_TILE_VAL +: TVAL_W] == TILE_WALL);
				n_writes++;
			end else begin
				src_col = data[TD_SRC_COL +: COORD_W];
				src_row = data[TD_SRC_ROW +: COORD_W];
				tgt_col = data[TD_TGT_COL +: COORD_W];
				tgt_row = data[TD_TGT_ROW +: COORD_W];
				want.reason = trace_sight(src_col, src_row, tgt_col, tgt_row);
				want.visible = (want.reason == REASON_CLEAR);
				expected_sight.push_back(want);
				n_queries++;
				case (want.reason)
					REASON_CLEAR: n_visible++;
					REASON_WALL:  n_wall++;
					default:      n_off_map++;
				endcase
			end
		endfunction

		function void check_result(logic [OUT_W-1:0] data);
			sight_result_t want;
			logic          got_visible;
			logic [1:0]    got_reason;
			got_visible = data[0];
			got_reason = data[2:1];
			if (expected_sight.size() == 0) begin
				errors++;
				$display("%0t: unexpected item visible=%0b reason=%0d", $time,
					got_visible, got_reason);
				return;
			end
			want = expected_sight.pop_front();
			if (got_visible !== want.visible) begin
				errors++;
				$display("%0t: visible expected %0b actual %0b", $time, want.visible,
					got_visible);
			end
			if (got_reason !== want.reason) begin
				errors++;
				$display("%0t: block_reason expected %0d actual %0d", $time, want.reason,
					got_reason);
			end
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n;
	logic             s_tvalid;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata;
	logic             s_tuser;
	logic             m_tvalid;
	logic             m_tready;
	logic [OUT_W-1:0] m_tdata;

	sight_board board = new();
	bit         steady = 1'b0;
	bit         hold_request = 1'b0;

	grid_line_of_sight i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				board.check_result(m_tdata);
			if (s_tvalid && s_tready)
				board.note_item(s_tuser, s_tdata);
		end
	end

	// receiver: short random stalls, or one long hold-off when asked
	initial begin
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				m_tready <= 1'b0;
				repeat (300) @(posedge clk);
			end else if (!steady && $urandom_range(0, 4) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 3)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	initial begin
		#(64'd20_000_000);
		$display("DONE: errors detected");
		$finish;
	end

	task automatic send_item(input logic cmd, input logic [IN_W-1:0] data);
		if (!steady && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= data;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	// query fields are filled with noise, the block must ignore them
	task automatic send_write(input int col, input int row, input int val);
		logic [IN_W-1:0] data;
		data = IN_W'({$urandom, $urandom});
		data[TD_TILE_COL +: TCOL_W] = TCOL_W'(col);
		data[TD_TILE_ROW +: TROW_W] = TROW_W'(row);
		data[TD_TILE_VAL +: TVAL_W] = TVAL_W'(val);
		send_item(CMD_WRITE, data);
	endtask

	task automatic send_query(input int src_col, input int src_row, input int tgt_col,
		input int tgt_row);
		logic [IN_W-1:0] data;
		data = IN_W'({$urandom, $urandom});
		data[TD_SRC_COL +: COORD_W] = COORD_W'(src_col);
		data[TD_SRC_ROW +: COORD_W] = COORD_W'(src_row);
		data[TD_TGT_COL +: COORD_W] = COORD_W'(tgt_col);
		data[TD_TGT_ROW +: COORD_W] = COORD_W'(tgt_row);
		send_item(CMD_QUERY, data);
	endtask

	// drop valid first and let the last accepted item reach the board, then wait
	task automatic wait_for_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (board.pending() != 0)
			@(posedge clk);
	endtask

	function automatic int near_coord();
		return $urandom_range(0, 15);
	endfunction

	function automatic int map_coord();
		return $urandom_range(0, 63);
	endfunction

	function automatic int any_coord();
		return int'($urandom_range(0, 511)) - 256;
	endfunction

	// walls are packed into one corner so that most lines meet some
	task automatic random_write();
		int col;
		int row;
		int val;
		col = ($urandom_range(0, 9) < 7) ? near_coord() : map_coord();
		row = ($urandom_range(0, 9) < 7) ? near_coord() : map_coord();
		val = ($urandom_range(0, 1) == 0) ? 1 : $urandom_range(0, 255);
		send_write(col, row, val);
	endtask

	task automatic random_query();
		int pick;
		int x;
		int y;
		pick = $urandom_range(0, 9);
		if (pick < 6)
			send_query(near_coord(), near_coord(), near_coord(), near_coord());
		else if (pick == 6)
			send_query(map_coord(), map_coord(), map_coord(), map_coord());
		else if (pick == 7)
			send_query(any_coord(), any_coord(), any_coord(), any_coord());
		else if (pick == 8)
			send_query(map_coord(), map_coord(), any_coord(), any_coord());
		else begin
			x = ($urandom_range(0, 1) == 0) ? near_coord() : any_coord();
			y = ($urandom_range(0, 1) == 0) ? near_coord() : any_coord();
			send_query(x, y, x, y);
		end
	endtask

	task automatic random_items(input int count);
		repeat (count) begin
			if ($urandom_range(0, 9) < 4)
				random_write();
			else
				random_query();
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tuser <= CMD_WRITE;
		s_tdata <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed corners
		send_query(0, 0, 0, 0);
		send_query(-256, -256, -256, -256);
		send_query(-256, 5, 3, 5);
		send_query(0, 0, 63, 63);
		send_write(63, 63, 1);
		send_query(0, 0, 63, 63);
		send_write(5, 0, 1);
		send_query(0, 0, 10, 0);
		send_query(5, 0, 5, 0);
		send_query(5, 0, 6, 0);
		send_write(5, 0, 255);
		send_query(0, 0, 10, 0);
		send_write(0, 63, 1);
		send_write(0, 63, 2);
		send_write(0, 0, 0);
		send_query(0, 0, 255, 255);
		send_query(63, 0, -256, 0);
		send_query(255, -256, 0, 0);
		send_query(10, 10, 64, 10);
		send_query(10, 10, 70, 10);
		send_query(-1, 0, 0, 0);
		send_write(2, 30, 1);
		send_query(0, 0, 3, 60);
		send_query(0, 0, 60, 3);
		wait_for_results();

		random_items(200);

		// receiver holds off while short queries keep coming
		hold_request = 1'b1;
		repeat (20)
			send_query(near_coord(), near_coord(), near_coord(), near_coord());
		wait_for_results();

		random_items(180);

		steady = 1'b1;
		random_items(50);

		wait_for_results();
		repeat (600) @(posedge clk);
		$display("covered %0d map writes and %0d queries", board.n_writes, board.n_queries);
		$display("query outcomes: %0d visible, %0d wall-blocked, %0d off-map",
			board.n_visible, board.n_wall, board.n_off_map);
		if (board.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
